// File: sv/gn2_pkg.sv
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared widths, constants, operation codes and control structs for the 2D
// gradient noise block.
// ----------------------------------------------------------------------------
package gn2_pkg;

   localparam int DEF_TABLE_SIZE = 256;
   localparam int DEF_FRAC_BITS  = 16;

   localparam int COORD_W = 32;   // input coordinate width
   localparam int PERM_W  = 8;    // permutation entry width
   localparam int T_W     = 16;   // fraction in Q0.16
   localparam int OFS_W   = 17;   // corner offset, signed Q16
   localparam int FADE_W  = 17;   // fade weight, 0 .. 1.0 in Q0.16
   localparam int DOT_W   = 18;   // corner dot product and blends, signed Q16
   localparam int NOISE_W = 16;   // result, signed Q1.15

   localparam logic [FADE_W-1:0] ONE_Q16  = 17'h10000;
   localparam int                DIAG_Q15 = 23170;

   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7fff;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   typedef struct packed {
      logic mul;
      logic mid;
      logic fin;
   } fade_en_type;

   typedef struct packed {
      logic mul;
      logic add;
   } lerp_en_type;

endpackage

// File: sv/gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise: permutation-table hashing, quintic fade and bilinear
// blend of four corner gradients, one point per cycle unless rsp_ready stalls.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per valid/ready handshake. An evaluate item
//   (req_operation = OP_EVAL) takes req_x_coord / req_y_coord in signed fixed
//   point with FRAC_BITS fraction bits and returns one rsp_noise_value in
//   signed Q1.15, saturated. A write item (OP_WRITE) stores req_perm_value at
//   req_perm_index and returns nothing; load every table entry that an
//   evaluate will touch before evaluating.
//   Throughput is one item per cycle unless a low rsp_ready stalls the
//   pipeline, writes and evaluates mixed freely. The table is kept in three
//   copies with two read ports each: one copy serves the two x-cell lookups,
//   two serve the four corner lookups, and every write goes to all three.
//   Writes land at the accept edge, in item order with the lookups.
//   Reset empties the pipeline; the table contents are not cleared.
//   When rsp_ready is low the result holds in the output register and the
//   eight stages fill their bubbles; req_ready drops only once stage one
//   holds an item that cannot move on.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
   parameter int TABLE_SIZE = gn2_pkg::DEF_TABLE_SIZE,
   parameter int FRAC_BITS  = gn2_pkg::DEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [gn2_pkg::COORD_W-1:0]   req_x_coord,
   input  logic signed [gn2_pkg::COORD_W-1:0]   req_y_coord,
   input  logic [gn2_pkg::PERM_W-1:0]           req_perm_index,
   input  logic [gn2_pkg::PERM_W-1:0]           req_perm_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gn2_pkg::NOISE_W-1:0]   rsp_noise_value
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int NUM_ST = 8;
   localparam int XE_W   = gn2_pkg::COORD_W + IDX_W;
   localparam int FT_W   = FRAC_BITS + gn2_pkg::T_W;
   localparam int EX_W   = IDX_W + gn2_pkg::PERM_W;
   localparam int H_W    = gn2_pkg::DOT_W - 1;
   localparam logic signed [gn2_pkg::DOT_W-1:0] DOT_LIM = 18'sd92682;

   // pipeline control
   logic [NUM_ST:1]   vld_ff, vld_in;
   logic [NUM_ST+1:1] rdy;

   // input decode
   logic [XE_W-1:0]         xe, ye;
   logic [FT_W-1:0]         fx, fy;
   logic [IDX_W-1:0]        cx0, cx1, cy0_in, cy1_in;
   logic [gn2_pkg::T_W-1:0] tx_in, ty_in;
   logic [EX_W-1:0]         wi_ext;
   logic                    eval_fire;

   // stage registers
   logic [gn2_pkg::T_W-1:0]    tx1_ff, ty1_ff, tx2_ff, ty2_ff;
   logic [IDX_W-1:0]           cy0_1_ff, cy1_1_ff;
   logic [gn2_pkg::FADE_W-1:0] v4_ff, v5_ff;

   // table access
   gn2_pkg::ram_ctl_type       ctl_x, ctl_c;
   logic [gn2_pkg::PERM_W-1:0] perm_a, perm_b;
   logic [EX_W-1:0]            pa_ext, pb_ext;
   logic [IDX_W-1:0]           pa_idx, pb_idx;
   logic [gn2_pkg::PERM_W-1:0] h00, h01, h10, h11;

   // arithmetic
   gn2_pkg::fade_en_type              fade_en;
   gn2_pkg::lerp_en_type              lx_en, ly_en;
   logic [gn2_pkg::FADE_W-1:0]        fade_u, fade_v;
   logic signed [gn2_pkg::OFS_W-1:0]  dx0, dx1, dy0, dy1;
   logic signed [gn2_pkg::DOT_W-1:0]  d00, d10, d01, d11;
   logic signed [gn2_pkg::DOT_W-1:0]  row0, row1, blend;
   logic signed [H_W-1:0]             half;
   logic signed [gn2_pkg::NOISE_W-1:0] noise_in, noise_ff;

   // ------------------------------------------------------------------
   // handshake and stage valids
   // ------------------------------------------------------------------
   always_comb begin
      rdy[NUM_ST+1] = rsp_ready;
      for (int k = NUM_ST; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[1];
   assign eval_fire = req_valid && req_operation == gn2_pkg::OP_EVAL;

   always_comb begin
      vld_in[1] = rdy[1] ? eval_fire : vld_ff[1];
      for (int k = 2; k <= NUM_ST; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------
   // cell and fraction split
   // ------------------------------------------------------------------
   assign xe     = {{IDX_W{req_x_coord[gn2_pkg::COORD_W-1]}}, req_x_coord};
   assign ye     = {{IDX_W{req_y_coord[gn2_pkg::COORD_W-1]}}, req_y_coord};
   assign cx0    = xe[FRAC_BITS +: IDX_W];
   assign cy0_in = ye[FRAC_BITS +: IDX_W];
   assign cx1    = cx0 + IDX_W'(1);
   assign cy1_in = cy0_in + IDX_W'(1);

   // bring the fraction to Q0.16: truncate or pad as FRAC_BITS dictates
   assign fx    = {req_x_coord[FRAC_BITS-1:0], gn2_pkg::T_W'(0)};
   assign fy    = {req_y_coord[FRAC_BITS-1:0], gn2_pkg::T_W'(0)};
   assign tx_in = fx[FT_W-1:FRAC_BITS];
   assign ty_in = fy[FT_W-1:FRAC_BITS];

   assign wi_ext = {IDX_W'(0), req_perm_index};

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         tx1_ff   <= tx_in;
         ty1_ff   <= ty_in;
         cy0_1_ff <= cy0_in;
         cy1_1_ff <= cy1_in;
      end
      if (rdy[2]) begin
         tx2_ff <= tx1_ff;
         ty2_ff <= ty1_ff;
      end
      if (rdy[4]) begin
         v4_ff <= fade_v;
      end
      if (rdy[5]) begin
         v5_ff <= v4_ff;
      end
      if (rdy[NUM_ST]) begin
         noise_ff <= noise_in;
      end
   end

   // ------------------------------------------------------------------
   // permutation lookups
   // ------------------------------------------------------------------
   assign ctl_x.wr_en = req_valid && rdy[1] && req_operation == gn2_pkg::OP_WRITE;
   assign ctl_x.rd_en = rdy[1];
   assign ctl_c.wr_en = ctl_x.wr_en;
   assign ctl_c.rd_en = rdy[2];

   gn2_perm_ram #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ram_x (
      .clock     (clock),
      .ctl       (ctl_x),
      .wr_addr   (wi_ext[IDX_W-1:0]),
      .wr_data   (req_perm_value),
      .rd_addr_a (cx0),
      .rd_addr_b (cx1),
      .rd_data_a (perm_a),
      .rd_data_b (perm_b)
   );

   assign pa_ext = {IDX_W'(0), perm_a};
   assign pb_ext = {IDX_W'(0), perm_b};
   assign pa_idx = pa_ext[IDX_W-1:0];
   assign pb_idx = pb_ext[IDX_W-1:0];

   gn2_perm_ram #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ram_c0 (
      .clock     (clock),
      .ctl       (ctl_c),
      .wr_addr   (wi_ext[IDX_W-1:0]),
      .wr_data   (req_perm_value),
      .rd_addr_a (pa_idx + cy0_1_ff),
      .rd_addr_b (pa_idx + cy1_1_ff),
      .rd_data_a (h00),
      .rd_data_b (h01)
   );

   gn2_perm_ram #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ram_c1 (
      .clock     (clock),
      .ctl       (ctl_c),
      .wr_addr   (wi_ext[IDX_W-1:0]),
      .wr_data   (req_perm_value),
      .rd_addr_a (pb_idx + cy0_1_ff),
      .rd_addr_b (pb_idx + cy1_1_ff),
      .rd_data_a (h10),
      .rd_data_b (h11)
   );

   // ------------------------------------------------------------------
   // fade weights, aligned with the dot products at stage three
   // ------------------------------------------------------------------
   assign fade_en.mul = rdy[1];
   assign fade_en.mid = rdy[2];
   assign fade_en.fin = rdy[3];

   gn2_fade u_fade_x (
      .clock (clock),
      .en    (fade_en),
      .t     (tx_in),
      .fade  (fade_u)
   );

   gn2_fade u_fade_y (
      .clock (clock),
      .en    (fade_en),
      .t     (ty_in),
      .fade  (fade_v)
   );

   // ------------------------------------------------------------------
   // corner dot products; t - 1.0 is the fraction with the sign bit set
   // ------------------------------------------------------------------
   assign dx0 = signed'({1'b0, tx2_ff});
   assign dx1 = signed'({1'b1, tx2_ff});
   assign dy0 = signed'({1'b0, ty2_ff});
   assign dy1 = signed'({1'b1, ty2_ff});

   gn2_dot u_dot00 (
      .clock (clock), .en (rdy[3]), .grad_sel (h00[2:0]),
      .dx (dx0), .dy (dy0), .dot (d00)
   );

   gn2_dot u_dot10 (
      .clock (clock), .en (rdy[3]), .grad_sel (h10[2:0]),
      .dx (dx1), .dy (dy0), .dot (d10)
   );

   gn2_dot u_dot01 (
      .clock (clock), .en (rdy[3]), .grad_sel (h01[2:0]),
      .dx (dx0), .dy (dy1), .dot (d01)
   );

   gn2_dot u_dot11 (
      .clock (clock), .en (rdy[3]), .grad_sel (h11[2:0]),
      .dx (dx1), .dy (dy1), .dot (d11)
   );

   // ------------------------------------------------------------------
   // bilinear blend: x rows, then y
   // ------------------------------------------------------------------
   assign lx_en.mul = rdy[4];
   assign lx_en.add = rdy[5];
   assign ly_en.mul = rdy[6];
   assign ly_en.add = rdy[7];

   gn2_lerp u_lerp_row0 (
      .clock (clock), .en (lx_en), .lo (d00), .hi (d10), .w (fade_u), .res (row0)
   );

   gn2_lerp u_lerp_row1 (
      .clock (clock), .en (lx_en), .lo (d01), .hi (d11), .w (fade_u), .res (row1)
   );

   gn2_lerp u_lerp_col (
      .clock (clock), .en (ly_en), .lo (row0), .hi (row1), .w (v5_ff), .res (blend)
   );

   // drop to Q1.15 and saturate
   assign half = blend[gn2_pkg::DOT_W-1:1];

   always_comb begin
      if (half[H_W-1] != half[H_W-2]) begin
         noise_in = half[H_W-1] ? gn2_pkg::NOISE_MIN : gn2_pkg::NOISE_MAX;
      end else begin
         noise_in = half[gn2_pkg::NOISE_W-1:0];
      end
   end

   assign rsp_valid       = vld_ff[NUM_ST];
   assign rsp_noise_value = noise_ff;

`ifndef NO_ASSERTIONS
   a_eval_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == gn2_pkg::OP_EVAL) |=> vld_ff[1])
      else $error("accepted evaluate item did not enter stage one");

   a_write_order: assert property (@(posedge clock) disable iff (reset)
      ctl_x.wr_en |-> (!vld_ff[1] || rdy[2]))
      else $error("table write overtook a pending corner lookup");

   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (fade_u <= gn2_pkg::ONE_Q16 && fade_v <= gn2_pkg::ONE_Q16))
      else $error("fade weight above 1.0");

   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (d00 <= DOT_LIM && d00 >= -DOT_LIM && d11 <= DOT_LIM
                     && d11 >= -DOT_LIM))
      else $error("corner dot product out of range");
`endif

endmodule

// File: sv/gn2_perm_ram.sv
// ----------------------------------------------------------------------------
// gn2_perm_ram
// Permutation table copy: one write port, two read ports with registered
// read data (old data on a same-edge write).
// ----------------------------------------------------------------------------
module gn2_perm_ram #(
   parameter int TABLE_SIZE = gn2_pkg::DEF_TABLE_SIZE
) (
   input  logic                              clock,
   input  gn2_pkg::ram_ctl_type              ctl,
   input  logic [$clog2(TABLE_SIZE)-1:0]     wr_addr,
   input  logic [gn2_pkg::PERM_W-1:0]        wr_data,
   input  logic [$clog2(TABLE_SIZE)-1:0]     rd_addr_a,
   input  logic [$clog2(TABLE_SIZE)-1:0]     rd_addr_b,
   output logic [gn2_pkg::PERM_W-1:0]        rd_data_a,
   output logic [gn2_pkg::PERM_W-1:0]        rd_data_b
);

   logic [gn2_pkg::PERM_W-1:0] mem [TABLE_SIZE];
   logic [gn2_pkg::PERM_W-1:0] rd_a_ff;
   logic [gn2_pkg::PERM_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data while the consuming stage is stalled
      if (ctl.rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: sv/gn2_fade.sv
// ----------------------------------------------------------------------------
// gn2_fade
// Quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16 over three multiply stages,
// clamped to 0 .. 1.0.
// ----------------------------------------------------------------------------
module gn2_fade (
   input  logic                         clock,
   input  gn2_pkg::fade_en_type         en,
   input  logic [gn2_pkg::T_W-1:0]      t,
   output logic [gn2_pkg::FADE_W-1:0]   fade
);

   localparam int A_W  = 21;
   localparam int P1_W = 38;
   localparam int SQ_W = 2 * gn2_pkg::T_W;
   localparam int SH_W = P1_W - 16;
   localparam logic signed [A_W-1:0] C15 = A_W'(15 * 65536);
   localparam logic signed [A_W-1:0] C10 = A_W'(10 * 65536);

   logic signed [A_W-1:0]      t_s;
   logic signed [A_W-1:0]      a_in;
   logic signed [P1_W-1:0]     p1_in, p1_ff;
   logic [SQ_W-1:0]            p2_in, p2_ff;
   logic [gn2_pkg::T_W-1:0]    t1_ff;
   logic signed [A_W-1:0]      b_in, b_ff;
   logic [SQ_W-1:0]            q3_in, q3_ff;
   logic signed [P1_W-1:0]     t3_s;
   logic signed [P1_W-1:0]     r_in;
   logic signed [SH_W-1:0]     f_sh;
   logic [gn2_pkg::FADE_W-1:0] fade_in, fade_ff;

   // first step: a = 6t - 15, a*t and t*t
   assign t_s   = signed'(A_W'(t));
   assign a_in  = (t_s <<< 2) + (t_s <<< 1) - C15;
   assign p1_in = P1_W'(a_in) * P1_W'(t_s);
   assign p2_in = SQ_W'(t) * SQ_W'(t);

   // second step: b = a*t + 10, t^3
   assign b_in  = A_W'(p1_ff >>> 16) + C10;
   assign q3_in = SQ_W'(p2_ff[SQ_W-1:16]) * SQ_W'(t1_ff);

   // third step: t^3 * b, then clamp
   assign t3_s = signed'(P1_W'(q3_ff[SQ_W-1:16]));
   assign r_in = t3_s * P1_W'(b_ff);
   assign f_sh = r_in[P1_W-1:16];

   always_comb begin
      if (f_sh < SH_W'(0)) begin
         fade_in = '0;
      end else if (f_sh > signed'(SH_W'(gn2_pkg::ONE_Q16))) begin
         fade_in = gn2_pkg::ONE_Q16;
      end else begin
         fade_in = gn2_pkg::FADE_W'(f_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         t1_ff <= t;
      end
      if (en.mid) begin
         b_ff  <= b_in;
         q3_ff <= q3_in;
      end
      if (en.fin) begin
         fade_ff <= fade_in;
      end
   end

   assign fade = fade_ff;

endmodule

// File: sv/gn2_dot.sv
// ----------------------------------------------------------------------------
// gn2_dot
// Corner gradient dot product. The low three hash bits pick the gradient:
// bit 2 clear selects a diagonal, with bit 0 and bit 1 negating x and y;
// bit 2 set selects an axis, bit 1 choosing y and bit 0 negating.
// ----------------------------------------------------------------------------
module gn2_dot (
   input  logic                               clock,
   input  logic                               en,
   input  logic [2:0]                         grad_sel,
   input  logic signed [gn2_pkg::OFS_W-1:0]   dx,
   input  logic signed [gn2_pkg::OFS_W-1:0]   dy,
   output logic signed [gn2_pkg::DOT_W-1:0]   dot
);

   localparam int S_W    = gn2_pkg::OFS_W + 2;
   localparam int AX_W   = gn2_pkg::OFS_W + 1;
   localparam int PROD_W = 34;
   localparam logic signed [PROD_W-1:0] DIAG = PROD_W'(gn2_pkg::DIAG_Q15);

   logic signed [S_W-1:0]             sx, sy, diag_sum;
   logic signed [gn2_pkg::OFS_W-1:0]  axis_pick;
   logic signed [AX_W-1:0]            axis_val;
   logic signed [PROD_W-1:0]          prod_in, prod_ff;

   assign sx       = grad_sel[0] ? -S_W'(dx) : S_W'(dx);
   assign sy       = grad_sel[1] ? -S_W'(dy) : S_W'(dy);
   assign diag_sum = sx + sy;

   assign axis_pick = grad_sel[1] ? dy : dx;
   assign axis_val  = grad_sel[0] ? -AX_W'(axis_pick) : AX_W'(axis_pick);

   // an axis gradient is 1.0 in Q1.15, so its product is a plain shift
   assign prod_in = grad_sel[2] ? (PROD_W'(axis_val) <<< 15)
                                : PROD_W'(diag_sum) * DIAG;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign dot = signed'(prod_ff[gn2_pkg::DOT_W+14:15]);

endmodule

// File: sv/gn2_lerp.sv
// ----------------------------------------------------------------------------
// gn2_lerp
// Linear blend lo + ((hi - lo) * w >> 16) in two stages: multiply, then add.
// The result stays between lo and hi, so it keeps their width.
// ----------------------------------------------------------------------------
module gn2_lerp (
   input  logic                               clock,
   input  gn2_pkg::lerp_en_type               en,
   input  logic signed [gn2_pkg::DOT_W-1:0]   lo,
   input  logic signed [gn2_pkg::DOT_W-1:0]   hi,
   input  logic [gn2_pkg::FADE_W-1:0]         w,
   output logic signed [gn2_pkg::DOT_W-1:0]   res
);

   localparam int DIFF_W = gn2_pkg::DOT_W + 1;
   localparam int PROD_W = DIFF_W + gn2_pkg::FADE_W + 1;
   localparam int SUM_W  = PROD_W - 16;

   logic signed [DIFF_W-1:0]          diff;
   logic signed [PROD_W-1:0]          w_s;
   logic signed [PROD_W-1:0]          prod_in, prod_ff;
   logic signed [gn2_pkg::DOT_W-1:0]  lo_ff;
   logic signed [SUM_W-1:0]           sum_in;
   logic signed [gn2_pkg::DOT_W-1:0]  res_ff;

   assign diff    = DIFF_W'(hi) - DIFF_W'(lo);
   assign w_s     = signed'(PROD_W'(w));
   assign prod_in = PROD_W'(diff) * w_s;
   assign sum_in  = SUM_W'(lo_ff) + SUM_W'(prod_ff >>> 16);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
         lo_ff   <= lo;
      end
      if (en.add) begin
         res_ff <= gn2_pkg::DOT_W'(sum_in);
      end
   end

   assign res = res_ff;

endmodule

// File: tb/tb_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Self-checking bench for the 2D gradient noise block. Loads the whole
// permutation table, runs a directed table (lattice points, coordinate
// extremes, cell wrap, every gradient direction), then random evaluates mixed
// with table writes. Both channels idle at random; every result is compared
// in order to a fixed result or a fixed-point predictor tracking the table.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     TBL            = gn2_pkg::DEF_TABLE_SIZE;
   localparam int     FRAC           = gn2_pkg::DEF_FRAC_BITS;
   localparam longint CELL_MASK      = TBL - 1;
   localparam longint UNIT           = 65536;
   localparam longint DIAG           = gn2_pkg::DIAG_Q15;
   localparam longint AXIS           = 32768;
   localparam int     RANDOM_ITEMS   = 770;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     PIPE_SETTLE    = 24;

   localparam logic FIXED_RESULT = 1'b1;
   localparam logic PREDICT      = 1'b0;

   typedef enum logic [2:0] {
      GRAD_DIAG_PP, GRAD_DIAG_NP, GRAD_DIAG_PN, GRAD_DIAG_NN,
      GRAD_POS_X, GRAD_NEG_X, GRAD_POS_Y, GRAD_NEG_Y
   } grad_dir_type;

   typedef struct packed {
      logic               op;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [7:0]         idx;
      logic [7:0]         val;
      logic               known;
      logic signed [15:0] noise;
   } probe_row_type;

   typedef struct packed {
      logic signed [15:0] noise;
      logic [31:0]        x;
      logic [31:0]        y;
   } noise_check_type;

   localparam int NPROBE = 24;

   // Cells (0,0) and (2,0) get corner hashes chosen so that every gradient
   // direction shows up; lattice points must give exactly zero.
   localparam probe_row_type PROBES [NPROBE] = '{
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd0,   8'd16,  PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd1,   8'd32,  PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd16,  8'd0,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd32,  8'd1,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd17,  8'd2,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd33,  8'd3,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd2,   8'd48,  PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd3,   8'd64,  PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd48,  8'd4,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd64,  8'd5,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd49,  8'd6,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd65,  8'd7,   PREDICT, 16'sh0},
      '{gn2_pkg::OP_WRITE, 32'h0, 32'h0, 8'd255, 8'd255, PREDICT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h0000_8000, 32'h0000_8000, 8'd0, 8'd0, PREDICT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h0002_4000, 32'h0000_C000, 8'd0, 8'd0, PREDICT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'd0, FIXED_RESULT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0, FIXED_RESULT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h7FFF_0000, 32'h8000_0000, 8'd0, 8'd0, FIXED_RESULT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h8000_0000, 32'h7FFF_0000, 8'd0, 8'd0, FIXED_RESULT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h7FFF_0000, 32'h7FFF_0000, 8'd0, 8'd0, FIXED_RESULT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, PREDICT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 8'd0, PREDICT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h00FF_8000, 32'hFFFF_8000, 8'd0, 8'd0, PREDICT, 16'sh0},
      '{gn2_pkg::OP_EVAL, 32'h0000_0001, 32'h0000_FFFF, 8'd0, 8'd0, PREDICT, 16'sh0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = gn2_pkg::OP_EVAL;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic [7:0]         req_perm_index = '0;
   logic [7:0]         req_perm_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_noise_value;

   logic [7:0]      lattice_perm [TBL];
   noise_check_type pending_noise [$];
   int              fail_count = 0;
   int              send_calm = 0;
   int              recv_calm = 0;
   int              quiet_cycles = 0;
   logic            req_took = 1'b0;
   logic            rsp_took = 1'b0;

   gradient_noise_2d #(
      .TABLE_SIZE(TBL),
      .FRAC_BITS (FRAC)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_perm_index (req_perm_index),
      .req_perm_value (req_perm_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_noise_value(rsp_noise_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---- predictor -----------------------------------------------------------

   function automatic longint frac_q16(longint raw);
      longint f;
      f = raw & ((64'sd1 <<< FRAC) - 1);
      if (FRAC >= 16)
         return f >>> ((FRAC >= 16) ? FRAC - 16 : 0);
      return f <<< ((FRAC < 16) ? 16 - FRAC : 0);
   endfunction

   function automatic longint fade_weight(longint t);
      longint a, b, t2, t3, f;
      a  = 6 * t - 15 * UNIT;
      b  = ((a * t) >>> 16) + 10 * UNIT;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      f  = (t3 * b) >>> 16;
      if (f < 0)
         f = 0;
      if (f > UNIT)
         f = UNIT;
      return f;
   endfunction

   function automatic int corner_hash(longint cx, longint cy);
      longint first;
      first = longint'(lattice_perm[int'(cx & CELL_MASK)]);
      return int'(lattice_perm[int'((first + cy) & CELL_MASK)]);
   endfunction

   function automatic longint corner_dot(int h, longint dx, longint dy);
      grad_dir_type dir;
      longint       gx, gy;
      dir = grad_dir_type'(h & 7);
      gx  = 0;
      gy  = 0;
      case (dir)
         GRAD_DIAG_PP: begin gx =  DIAG; gy =  DIAG; end
         GRAD_DIAG_NP: begin gx = -DIAG; gy =  DIAG; end
         GRAD_DIAG_PN: begin gx =  DIAG; gy = -DIAG; end
         GRAD_DIAG_NN: begin gx = -DIAG; gy = -DIAG; end
         GRAD_POS_X:   gx =  AXIS;
         GRAD_NEG_X:   gx = -AXIS;
         GRAD_POS_Y:   gy =  AXIS;
         default:      gy = -AXIS;
      endcase
      return (gx * dx + gy * dy) >>> 15;
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      return a + (((b - a) * w) >>> 16);
   endfunction

   function automatic logic signed [15:0] noise_at(logic signed [31:0] x,
                                                   logic signed [31:0] y);
      longint xs, ys, cx, cy, tx, ty, u, v, d00, d10, d01, d11, r;
      xs  = x;
      ys  = y;
      cx  = xs >>> FRAC;
      cy  = ys >>> FRAC;
      tx  = frac_q16(xs);
      ty  = frac_q16(ys);
      u   = fade_weight(tx);
      v   = fade_weight(ty);
      d00 = corner_dot(corner_hash(cx,     cy),     tx,        ty);
      d10 = corner_dot(corner_hash(cx + 1, cy),     tx - UNIT, ty);
      d01 = corner_dot(corner_hash(cx,     cy + 1), tx,        ty - UNIT);
      d11 = corner_dot(corner_hash(cx + 1, cy + 1), tx - UNIT, ty - UNIT);
      r   = blend(blend(d00, d10, u), blend(d01, d11, u), v) >>> 1;
      if (r > longint'(gn2_pkg::NOISE_MAX))
         r = longint'(gn2_pkg::NOISE_MAX);
      if (r < longint'(gn2_pkg::NOISE_MIN))
         r = longint'(gn2_pkg::NOISE_MIN);
      return r[15:0];
   endfunction

   // ---- stimulus helpers ----------------------------------------------------

   // Mostly random idle, with runs of back-to-back items.
   function automatic int draw_pause(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [31:0] pick_coord();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 5))
         0: c = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         1: begin
            case ($urandom_range(0, 3))
               0: c[15:0] = 16'h0000;
               1: c[15:0] = 16'h0001;
               2: c[15:0] = 16'h8000;
               default: c[15:0] = 16'hFFFF;
            endcase
         end
         2: begin
            case ($urandom_range(0, 3))
               0: c = 32'h7FFF_FFFF;
               1: c = 32'h8000_0000;
               2: c = 32'hFFFF_FFFF;
               default: c = 32'h8000_0001;
            endcase
         end
         default: ;
      endcase
      return c;
   endfunction

   // Drive one item, wait for its handshake, then record what it should cause.
   task automatic send_item(input logic op, input logic [31:0] x, input logic [31:0] y,
                            input logic [7:0] idx, input logic [7:0] val,
                            input logic known, input logic signed [15:0] noise);
      int              gap;
      noise_check_type chk;
      gap = draw_pause(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_x_coord    <= x;
      req_y_coord    <= y;
      req_perm_index <= idx;
      req_perm_value <= val;
      @(negedge clock);
      while (!req_ready)
         @(negedge clock);
      @(posedge clock);
      if (op == gn2_pkg::OP_WRITE) begin
         lattice_perm[int'(longint'(idx) & CELL_MASK)] = val;
      end else begin
         chk.x     = x;
         chk.y     = y;
         chk.noise = (known == FIXED_RESULT) ? noise : noise_at(x, y);
         pending_noise = {pending_noise, chk};
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_noise.size() != 0);
   endtask

   // ---- handshake sampling and watchdog -------------------------------------

   always @(negedge clock) begin
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
   end

   always @(posedge clock) begin
      if (reset || req_took || rsp_took) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---- result side ---------------------------------------------------------

   initial begin
      int              gap;
      noise_check_type want;
      while (reset)
         @(posedge clock);
      forever begin
         gap = draw_pause(recv_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid)
            @(negedge clock);
         if (pending_noise.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected noise item %0d", rsp_noise_value);
         end else begin
            want = pending_noise.pop_front();
            if (rsp_noise_value !== want.noise) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("noise at (%h,%h): expected %0d, got %0d",
                           want.x, want.y, want.noise, rsp_noise_value);
            end
         end
         @(posedge clock);
      end
   end

   // ---- main sequence -------------------------------------------------------

   initial begin
      logic        op;
      logic [31:0] x, y;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Every entry written before the first evaluate.
      for (int i = 0; i < TBL; i++)
         send_item(gn2_pkg::OP_WRITE, $urandom, $urandom, 8'(i),
                   8'($urandom_range(0, 255)), PREDICT, 16'sh0);

      for (int k = 0; k < NPROBE; k++)
         send_item(PROBES[k].op, PROBES[k].x, PROBES[k].y, PROBES[k].idx,
                   PROBES[k].val, PROBES[k].known, PROBES[k].noise);

      hold_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op = ($urandom_range(0, 7) == 0) ? gn2_pkg::OP_WRITE : gn2_pkg::OP_EVAL;
         x  = (op == gn2_pkg::OP_EVAL) ? pick_coord() : $urandom;
         y  = (op == gn2_pkg::OP_EVAL) ? pick_coord() : $urandom;
         send_item(op, x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   PREDICT, 16'sh0);
         if ($urandom_range(0, 149) == 0)
            hold_until_drained();
      end

      req_valid <= 1'b0;
      while (pending_noise.size() != 0)
         @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
